FILE: rtl/abd_pkg.sv
// Package for the ADPCM block decoder: widths, predictor coefficient
// tables and the control struct of the shared multiply-accumulate unit.
// No dependencies.
package abd_pkg;

   // Accumulator width: nibble term << 6 plus both taps stays below 2^24
   localparam int ACC_W = 26;
   localparam int COEF_W = 8;
   localparam int SAMPLE_W = 16;
   localparam int FRAC_W = 6;
   localparam int ROUND_VAL = 32;

   // Control of the multiply-accumulate unit
   typedef struct packed {
      logic en;     // update the accumulator
      logic load;   // start from the init value instead of the accumulator
   } mac_ctrl_type;

   // Coefficient applied to the newest sample
   function automatic logic signed [COEF_W-1:0] coef_a(input logic [3:0] idx);
      logic signed [COEF_W-1:0] c;
      case (idx)
         4'd1:    c = 8'sd60;
         4'd2:    c = 8'sd115;
         4'd3:    c = 8'sd98;
         4'd4:    c = 8'sd122;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

   // Coefficient applied to the older sample
   function automatic logic signed [COEF_W-1:0] coef_b(input logic [3:0] idx);
      logic signed [COEF_W-1:0] c;
      case (idx)
         4'd2:    c = -8'sd52;
         4'd3:    c = -8'sd55;
         4'd4:    c = -8'sd60;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/abd_mac.sv
// Shared multiply-accumulate unit of the ADPCM block decoder.
// One signed coefficient times one history sample per cycle. Uses abd_pkg.
module abd_mac (
   input  logic                                 clock,
   input  abd_pkg::mac_ctrl_type                ctrl,
   input  logic signed [abd_pkg::ACC_W-1:0]     init,
   input  logic signed [abd_pkg::COEF_W-1:0]    coef,
   input  logic signed [abd_pkg::SAMPLE_W-1:0]  operand,
   output logic signed [abd_pkg::ACC_W-1:0]     acc
);

   localparam int PROD_W = abd_pkg::COEF_W + abd_pkg::SAMPLE_W;

   logic signed [PROD_W-1:0]         product;
   logic signed [abd_pkg::ACC_W-1:0] product_ext;
   logic signed [abd_pkg::ACC_W-1:0] acc_ff;
   logic signed [abd_pkg::ACC_W-1:0] acc_in;

   // one multiply, one add
   assign product     = coef * operand;
   assign product_ext = {{(abd_pkg::ACC_W-PROD_W){product[PROD_W-1]}}, product};
   assign acc_in      = (ctrl.load ? init : acc_ff) + product_ext;

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

FILE: rtl/adpcm_block_decoder.sv
// Top level of the 4-bit ADPCM block decoder: sequencer, history and
// output register around the shared multiply-accumulate unit (abd_mac).
// Uses abd_pkg.
//
// Usage:
//   Input channel req_*: req_action 0 carries a block header word (low byte
//   sets shift amount and predictor index), req_action 1 a data word of
//   four nibbles. An item is taken when req_valid is high and req_stall low.
//   Result channel rsp_*: four samples per data word, lowest nibble first,
//   rsp_last marks the fourth. A sample is taken when rsp_valid is high and
//   rsp_stall low.
// Sequence:
//   A header is taken in IDLE and gives no result. A data word holds the
//   input stalled until its fourth sample is loaded into the output
//   register: each sample needs two passes through the single
//   multiplier (one per prediction tap) and an EMIT step to saturate and load
//   the output register, in the order TAP_A, TAP_B, EMIT.
// Stalls: a held result keeps its value; the next sample waits in the
//   accumulator until the output register is free.
// Reset: clears shift, predictor index and both history samples to zero
//   and drops rsp_valid.
module adpcm_block_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic [15:0]                          req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [abd_pkg::SAMPLE_W-1:0]  rsp_sample,
   output logic                                 rsp_last
);

   localparam int ACC_W = abd_pkg::ACC_W;
   localparam int SW    = abd_pkg::SAMPLE_W;
   localparam int QW    = ACC_W - abd_pkg::FRAC_W;
   localparam int TW    = SW + abd_pkg::FRAC_W;
   localparam logic signed [ACC_W-1:0] ROUND   = ACC_W'(abd_pkg::ROUND_VAL);
   localparam logic signed [QW-1:0]    SAT_MAX = QW'(32767);
   localparam logic signed [QW-1:0]    SAT_MIN = -QW'(32768);

   typedef enum logic [1:0] {
      IDLE,
      TAP_A,
      TAP_B,
      EMIT
   } state_type;

   state_type                state_ff;
   logic [3:0]               shift_ff;
   logic [3:0]               pidx_ff;
   logic signed [SW-1:0]     hist_new_ff;
   logic signed [SW-1:0]     hist_old_ff;
   logic [15:0]              word_ff;
   logic [1:0]               nib_ff;
   logic                     rsp_valid_ff;
   logic signed [SW-1:0]     rsp_sample_ff;
   logic                     rsp_last_ff;

   logic [15:0]              word_sh;
   logic signed [SW-1:0]     nib_ext;
   logic signed [SW-1:0]     term;
   logic signed [ACC_W-1:0]  init;
   abd_pkg::mac_ctrl_type    mac_ctrl;
   logic signed [abd_pkg::COEF_W-1:0] mac_coef;
   logic signed [SW-1:0]     mac_operand;
   logic signed [ACC_W-1:0]  acc;
   logic signed [QW-1:0]     acc_q;
   logic signed [SW-1:0]     pcm;
   logic                     out_free;
   logic                     req_take;

   // nibble term: nibble at bit 12, arithmetic shift right
   assign word_sh = word_ff >> {nib_ff, 2'b00};
   assign nib_ext = {word_sh[3:0], 12'd0};
   assign term    = nib_ext >>> shift_ff;
   assign init    = {{(ACC_W-TW){term[SW-1]}}, term, {abd_pkg::FRAC_W{1'b0}}} + ROUND;

   // shared unit control: newest tap first, then older tap
   always_comb begin
      mac_ctrl    = '0;
      mac_coef    = abd_pkg::coef_a(pidx_ff);
      mac_operand = hist_new_ff;
      case (state_ff)
         TAP_A: begin
            mac_ctrl.en   = 1'b1;
            mac_ctrl.load = 1'b1;
         end
         TAP_B: begin
            mac_ctrl.en = 1'b1;
            mac_coef    = abd_pkg::coef_b(pidx_ff);
            mac_operand = hist_old_ff;
         end
         default: begin
            mac_ctrl = '0;
         end
      endcase
   end

   abd_mac u_mac (
      .clock   (clock),
      .ctrl    (mac_ctrl),
      .init    (init),
      .coef    (mac_coef),
      .operand (mac_operand),
      .acc     (acc)
   );

   // drop fraction bits and saturate
   assign acc_q = QW'(acc >>> abd_pkg::FRAC_W);
   always_comb begin
      if (acc_q > SAT_MAX) begin
         pcm = SAT_MAX[SW-1:0];
      end else if (acc_q < SAT_MIN) begin
         pcm = SAT_MIN[SW-1:0];
      end else begin
         pcm = acc_q[SW-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_take = req_valid && !req_stall;

   // sequencer, history and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         shift_ff     <= '0;
         pidx_ff      <= '0;
         hist_new_ff  <= '0;
         hist_old_ff  <= '0;
         nib_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // EMIT owns the output register while it is in that state
         if (rsp_valid_ff && !rsp_stall && state_ff != EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_take) begin
                  if (req_action) begin
                     word_ff  <= req_word;
                     nib_ff   <= '0;
                     state_ff <= TAP_A;
                  end else begin
                     shift_ff <= req_word[3:0];
                     pidx_ff  <= req_word[7:4];
                  end
               end
            end
            TAP_A: begin
               state_ff <= TAP_B;
            end
            TAP_B: begin
               state_ff <= EMIT;
            end
            EMIT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_sample_ff <= pcm;
                  rsp_last_ff   <= (nib_ff == 2'd3);
                  hist_old_ff   <= hist_new_ff;
                  hist_new_ff   <= pcm;
                  nib_ff        <= nib_ff + 2'd1;
                  state_ff      <= (nib_ff == 2'd3) ? IDLE : TAP_A;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign req_stall  = (state_ff != IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

   // a data item always blocks the input for its four samples
   a_data_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action |=> req_stall)
      else $error("data item did not start the sequencer");

   // a stalled sample stays valid and unchanged until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_last))
      else $error("stalled sample changed or dropped");

   // nibble counter is back at zero whenever the sequencer is idle
   a_nib_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE) |-> (nib_ff == 2'd0))
      else $error("nibble counter not cleared at end of word");

endmodule

FILE: dv/adpcm_block_decoder_test.sv
// Self-checking testbench for adpcm_block_decoder: drives header and data
// items, predicts every decoded sample and checks the result stream.
// Depends on abd_pkg and the adpcm_block_decoder RTL.
`timescale 1ns / 100ps

module adpcm_block_decoder_test;

   // Action codes of the input item
   localparam logic ACT_HEADER = 1'b0;
   localparam logic ACT_DATA   = 1'b1;

   // Cycles without any accepted item before the run is declared hung
   localparam int IDLE_LIMIT = 2000;

   // Prediction taps by predictor index; unused indices give zero
   localparam int TAP_NEWEST [16] = '{0, 60, 115, 98, 122, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
   localparam int TAP_OLDER  [16] = '{0, 0, -52, -55, -60, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

   typedef struct packed {
      logic        action;
      logic [15:0] word;
   } block_item_type;

   typedef struct packed {
      logic signed [abd_pkg::SAMPLE_W-1:0] sample;
      logic                                last;
   } pcm_result_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = ACT_HEADER;
   logic [15:0] req_word = 16'h0000;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [abd_pkg::SAMPLE_W-1:0] rsp_sample;
   logic rsp_last;

   block_item_type pending_items [$];
   pcm_result_type expected_samples [$];

   // Decoder state as predicted
   logic [3:0] cur_shift = 4'd0;
   logic [3:0] cur_index = 4'd0;
   logic signed [abd_pkg::SAMPLE_W-1:0] hist_newest = '0;
   logic signed [abd_pkg::SAMPLE_W-1:0] hist_older = '0;

   int mismatch_count = 0;
   int idle_cycles = 0;
   logic req_taken = 1'b0;
   int burst_left = 8;
   int gap_left = 0;
   block_item_type next_item;
   stall_mode_type stall_mode = STALL_NONE;
   int stall_span = 50;

   adpcm_block_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_sample (rsp_sample),
      .rsp_last   (rsp_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   task automatic queue_item(input logic action, input logic [15:0] word);
      block_item_type item;
      item.action = action;
      item.word = word;
      pending_items.push_back(item);
   endtask

   // Header latches shift and index; data word expands to four samples
   task automatic decode_item(input logic action, input logic [15:0] word);
      logic signed [3:0] nib;
      int term;
      int pred;
      int pcm;
      pcm_result_type res;
      if (action == ACT_HEADER) begin
         cur_shift = word[3:0];
         cur_index = word[7:4];
      end else begin
         for (int k = 0; k < 4; k++) begin
            nib = word[4*k +: 4];
            term = (int'(nib) * 4096) >>> cur_shift;
            pred = (TAP_NEWEST[cur_index] * int'(hist_newest) +
                    TAP_OLDER[cur_index] * int'(hist_older) +
                    abd_pkg::ROUND_VAL) >>> abd_pkg::FRAC_W;
            pcm = term + pred;
            if (pcm > 32767)
               pcm = 32767;
            else if (pcm < -32768)
               pcm = -32768;
            hist_older = hist_newest;
            hist_newest = pcm[abd_pkg::SAMPLE_W-1:0];
            res.sample = pcm[abd_pkg::SAMPLE_W-1:0];
            res.last = (k == 3);
            expected_samples.push_back(res);
         end
      end
   endtask

   // Sender: bursts of items separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            next_item = pending_items.pop_front();
            req_valid <= 1'b1;
            req_action <= next_item.action;
            req_word <= next_item.word;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               if ($urandom_range(0, 2) == 0)
                  gap_left <= 0;
               else if ($urandom_range(0, 9) == 0)
                  gap_left <= $urandom_range(10, 24);
               else
                  gap_left <= $urandom_range(1, 5);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern switches between modes after a random span
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_span <= $urandom_range(20, 150);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
         default:        rsp_stall <= ((stall_span % 8) < 3);
      endcase
   end

   // Predict on each accepted item, check each accepted sample
   always @(posedge clock) begin
      pcm_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            decode_item(req_action, req_word);
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected sample", int'(rsp_sample), 0);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample !== want.sample)
                  report_mismatch("sample", int'(rsp_sample), int'(want.sample));
               if (rsp_last !== want.last)
                  report_mismatch("last flag", int'(rsp_last), int'(want.last));
            end
         end
      end
   end

   // Watchdog on cycles with no accepted item on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("adpcm_block_decoder_test failed");
            $finish;
         end
      end
   end

   initial begin
      int kind;
      int nwords;
      logic [3:0] shift_val;
      logic [3:0] index_val;
      logic [15:0] data_val;

      // Data before any header runs with shift 0, index 0
      queue_item(ACT_DATA, 16'h8F70);
      // Single tap, positive saturation
      queue_item(ACT_HEADER, 16'h0010);
      queue_item(ACT_DATA, 16'h7777);
      queue_item(ACT_DATA, 16'h7777);
      // Strongest predictor, negative saturation; high byte set but ignored
      queue_item(ACT_HEADER, 16'hFF40);
      queue_item(ACT_DATA, 16'h8888);
      queue_item(ACT_DATA, 16'h8888);
      queue_item(ACT_DATA, 16'h7777);
      queue_item(ACT_HEADER, 16'h002C);
      queue_item(ACT_DATA, 16'h1234);
      // Large shifts leave only a few units of nibble term
      queue_item(ACT_HEADER, 16'h003D);
      queue_item(ACT_DATA, 16'hFFFF);
      queue_item(ACT_HEADER, 16'h005E);
      queue_item(ACT_DATA, 16'h8000);
      queue_item(ACT_HEADER, 16'h00FF);
      queue_item(ACT_DATA, 16'hF8F8);
      queue_item(ACT_DATA, 16'h7070);
      queue_item(ACT_HEADER, 16'h5A07);
      queue_item(ACT_DATA, 16'hFFFF);
      queue_item(ACT_DATA, 16'h0000);
      // Back-to-back headers: the second one wins
      queue_item(ACT_HEADER, 16'h0031);
      queue_item(ACT_HEADER, 16'h0042);
      queue_item(ACT_DATA, 16'hA5C3);
      // History carries across the block boundary
      queue_item(ACT_HEADER, 16'h0040);
      queue_item(ACT_DATA, 16'h0000);

      // Mostly well-formed blocks, some stray data words and stray headers
      while (pending_items.size() < 475) begin
         kind = $urandom_range(0, 99);
         if (kind < 88) begin
            shift_val = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(13, 15))
                                                    : 4'($urandom_range(0, 12));
            index_val = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(5, 15))
                                                    : 4'($urandom_range(0, 4));
            queue_item(ACT_HEADER, {8'($urandom), index_val, shift_val});
            nwords = $urandom_range(1, 7);
            repeat (nwords) begin
               if ($urandom_range(0, 9) == 0) begin
                  case ($urandom_range(0, 3))
                     0:       data_val = 16'h7777;
                     1:       data_val = 16'h8888;
                     2:       data_val = 16'h0000;
                     default: data_val = 16'hFFFF;
                  endcase
               end else begin
                  data_val = 16'($urandom);
               end
               queue_item(ACT_DATA, data_val);
            end
         end else if (kind < 94) begin
            queue_item(ACT_DATA, 16'($urandom));
         end else begin
            queue_item(ACT_HEADER, 16'($urandom));
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: all items sent, all samples seen, then a settling margin
      while (pending_items.size() != 0 || req_valid)
         @(negedge clock);
      while (expected_samples.size() != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);

      if (mismatch_count == 0 && expected_samples.size() == 0)
         $display("adpcm_block_decoder_test passed");
      else
         $display("adpcm_block_decoder_test failed");
      $finish;
   end

endmodule
